@@ design/dccf_pkg.sv @@
`default_nettype none

package dccf_pkg;

  // Chained chips per write frame and the widths that follow from it.
  localparam int MAX_CHIPS = 8;
  localparam int CNT_W     = $clog2(MAX_CHIPS + 1);
  localparam int IDX_W     = (MAX_CHIPS > 1) ? $clog2(MAX_CHIPS) : 1;

  // Field widths.
  localparam int CMD_W   = 16;
  localparam int GRP_W   = 48;
  localparam int PEC_W   = 16;
  localparam int REM_W   = 15;
  localparam int CHIPS_W = 4;
  localparam int CFG_W   = 15;
  localparam int BCNT_W  = 3;

  // Bytes covered by one PEC.
  localparam logic [BCNT_W-1:0] CMD_BYTES = 3'd2;
  localparam logic [BCNT_W-1:0] GRP_BYTES = 3'd6;

  // Register reset values.
  localparam logic [CHIPS_W-1:0] CHIPS_RST = 4'd1;
  localparam logic [REM_W-1:0]   SEED_RST  = 15'd16;
  localparam logic [REM_W-1:0]   POLY_RST  = 15'h4599;

  // Input action codes.
  typedef enum logic [1:0] {
    ACT_CMD = 2'd0,
    ACT_HDR = 2'd1,
    ACT_GRP = 2'd2
  } action_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_CHIP_COUNT = 2'd0,
    REG_PEC_SEED   = 2'd1,
    REG_PEC_POLY   = 2'd2
  } reg_idx_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_cmd;   // capture a command word and start its PEC
    logic cmd_end;    // the command word closes the frame
    logic store_grp;  // store an incoming register group
    logic start_dump; // begin sending all held groups
    logic load_grp;   // fetch the next held group and start its PEC
    logic pec_step;   // fold one byte into the PEC remainder
  } dccf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dump_due;   // storing this group fills the frame
    logic pec_last;   // the current byte is the final one of the word
    logic word_last;  // the word on the output is the last of its run
  } dccf_sts_t;

  // CRC15 table entry for one address under the given polynomial.
  function automatic logic [REM_W-1:0] pec_table(input logic [7:0] addr,
                                                 input logic [REM_W-1:0] poly);
    logic [REM_W-1:0] r;
    r = {addr, 7'd0};
    for (int b = 0; b < 8; b++) begin
      if (r[REM_W-1]) begin
        r = {r[REM_W-2:0], 1'b0} ^ poly;
      end else begin
        r = {r[REM_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/dccf_ctrl.sv @@
`default_nettype none

module dccf_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  input  wire logic [1:0]         in_tuser,
  input  wire logic               out_tready,
  input  wire dccf_pkg::dccf_sts_t sts,
  output dccf_pkg::dccf_cmd_t     cmd,
  output logic                    in_tready,
  output logic                    out_tvalid
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_CALC = 4'b0100,
    ST_SEND = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  dccf_pkg::action_t action;

  assign action     = dccf_pkg::action_t'(in_tuser);
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_SEND);

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          unique case (action) inside
            dccf_pkg::ACT_CMD, dccf_pkg::ACT_HDR: begin
              cmd.load_cmd = 1'b1;
              cmd.cmd_end  = (action == dccf_pkg::ACT_CMD);
              state_nxt    = ST_CALC;
            end
            dccf_pkg::ACT_GRP: begin
              cmd.store_grp = 1'b1;
              if (sts.dump_due) begin
                cmd.start_dump = 1'b1;
                state_nxt      = ST_LOAD;
              end
            end
            default: begin
              // Unused action code: the transaction is dropped.
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_LOAD: begin
        cmd.load_grp = 1'b1;
        state_nxt    = ST_CALC;
      end
      ST_CALC: begin
        cmd.pec_step = 1'b1;
        if (sts.pec_last) begin
          state_nxt = ST_SEND;
        end
      end
      ST_SEND: begin
        if (out_tready) begin
          state_nxt = sts.word_last ? ST_IDLE : ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/dccf_datapath.sv @@
`default_nettype none

module dccf_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_valid,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [dccf_pkg::CFG_W-1:0] cfg_data,
  input  wire logic [63:0]                in_tdata,
  input  wire dccf_pkg::dccf_cmd_t        cmd,
  output dccf_pkg::dccf_sts_t             sts,
  output logic [63:0]                     out_tdata,
  output logic [1:0]                      out_tuser,
  output logic                            out_tlast
);

  // Configuration registers.
  logic [dccf_pkg::CHIPS_W-1:0] chip_count_r;
  logic [dccf_pkg::REM_W-1:0]   pec_seed_r;
  logic [dccf_pkg::REM_W-1:0]   pec_poly_r;

  // Group store and frame bookkeeping.
  logic [dccf_pkg::GRP_W-1:0]  store_r [dccf_pkg::MAX_CHIPS];
  logic [dccf_pkg::CNT_W-1:0]  held_r, held_nxt;
  logic [dccf_pkg::CNT_W-1:0]  emit_r, emit_nxt;
  logic [dccf_pkg::BCNT_W-1:0] bcnt_r, bcnt_nxt;

  // Word under work and output payload.
  logic [dccf_pkg::GRP_W-1:0] word_r;
  logic [dccf_pkg::GRP_W-1:0] shift_r;
  logic [dccf_pkg::REM_W-1:0] rem_r;
  logic                       kind_r;
  logic                       fend_r;
  logic                       last_r;

  logic [dccf_pkg::CNT_W-1:0] eff_cnt;
  logic [dccf_pkg::CNT_W-1:0] held_inc;
  logic [dccf_pkg::IDX_W-1:0] rd_idx;
  logic [dccf_pkg::CMD_W-1:0] in_cmd;
  logic [dccf_pkg::GRP_W-1:0] in_grp;
  logic [7:0]                 pec_addr;
  logic [dccf_pkg::REM_W-1:0] rem_step;

  assign in_cmd = in_tdata[dccf_pkg::CMD_W-1:0];
  assign in_grp = in_tdata[63:dccf_pkg::CMD_W];

  // Effective chip count: zero counts as one, saturated at the store depth.
  always_comb begin
    if (chip_count_r == '0) begin
      eff_cnt = dccf_pkg::CNT_W'(1);
    end else if (int'(chip_count_r) > dccf_pkg::MAX_CHIPS) begin
      eff_cnt = dccf_pkg::CNT_W'(dccf_pkg::MAX_CHIPS);
    end else begin
      eff_cnt = dccf_pkg::CNT_W'(chip_count_r);
    end
  end

  // Held count after storing one more group; a full store keeps its count.
  assign held_inc = (int'(held_r) < dccf_pkg::MAX_CHIPS) ?
                    held_r + dccf_pkg::CNT_W'(1) : held_r;
  assign rd_idx   = dccf_pkg::IDX_W'(emit_r - dccf_pkg::CNT_W'(1));

  // One byte of the table-driven CRC15 per cycle, top byte first.
  assign pec_addr = rem_r[14:7] ^ shift_r[dccf_pkg::GRP_W-1 -: 8];
  assign rem_step = {rem_r[6:0], 8'd0} ^ dccf_pkg::pec_table(pec_addr, pec_poly_r);

  assign sts.dump_due  = (held_inc >= eff_cnt);
  assign sts.pec_last  = (bcnt_r == dccf_pkg::BCNT_W'(1));
  assign sts.word_last = last_r;

  // Counter updates.
  always_comb begin
    held_nxt = held_r;
    emit_nxt = emit_r;
    bcnt_nxt = bcnt_r;
    if (cmd.load_cmd) begin
      held_nxt = '0;
      bcnt_nxt = dccf_pkg::CMD_BYTES;
    end
    if (cmd.store_grp) begin
      held_nxt = held_inc;
    end
    if (cmd.start_dump) begin
      held_nxt = '0;
      emit_nxt = held_inc;
    end
    if (cmd.load_grp) begin
      emit_nxt = emit_r - dccf_pkg::CNT_W'(1);
      bcnt_nxt = dccf_pkg::GRP_BYTES;
    end
    if (cmd.pec_step) begin
      bcnt_nxt = bcnt_r - dccf_pkg::BCNT_W'(1);
    end
  end

  // Control registers and configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chip_count_r <= dccf_pkg::CHIPS_RST;
      pec_seed_r   <= dccf_pkg::SEED_RST;
      pec_poly_r   <= dccf_pkg::POLY_RST;
      held_r       <= '0;
      emit_r       <= '0;
      bcnt_r       <= '0;
    end else begin
      held_r <= held_nxt;
      emit_r <= emit_nxt;
      bcnt_r <= bcnt_nxt;
      if (cfg_valid) begin
        unique case (dccf_pkg::reg_idx_t'(cfg_index))
          dccf_pkg::REG_CHIP_COUNT: chip_count_r <= cfg_data[dccf_pkg::CHIPS_W-1:0];
          dccf_pkg::REG_PEC_SEED:   pec_seed_r   <= cfg_data;
          dccf_pkg::REG_PEC_POLY:   pec_poly_r   <= cfg_data;
          default: begin
            // Writes beyond the register list are ignored.
          end
        endcase
      end
    end
  end

  // Group store: a group is kept only while there is room.
  always_ff @(posedge clk) begin
    if (cmd.store_grp && (int'(held_r) < dccf_pkg::MAX_CHIPS)) begin
      store_r[dccf_pkg::IDX_W'(held_r)] <= in_grp;
    end
  end

  // Word, PEC remainder and output flags.
  always_ff @(posedge clk) begin
    if (cmd.load_cmd) begin
      word_r  <= {{(dccf_pkg::GRP_W-dccf_pkg::CMD_W){1'b0}}, in_cmd};
      shift_r <= {in_cmd, {(dccf_pkg::GRP_W-dccf_pkg::CMD_W){1'b0}}};
      rem_r   <= pec_seed_r;
      kind_r  <= 1'b0;
      fend_r  <= cmd.cmd_end;
      last_r  <= 1'b1;
    end else if (cmd.load_grp) begin
      word_r  <= store_r[rd_idx];
      shift_r <= store_r[rd_idx];
      rem_r   <= pec_seed_r;
      kind_r  <= 1'b1;
      fend_r  <= (emit_r == dccf_pkg::CNT_W'(1));
      last_r  <= (emit_r == dccf_pkg::CNT_W'(1));
    end else if (cmd.pec_step) begin
      shift_r <= {shift_r[dccf_pkg::GRP_W-9:0], 8'd0};
      rem_r   <= rem_step;
    end
  end

  // Output payload: tdata is {word_pec, word_data}, tuser is {last, word_kind}.
  assign out_tdata = {rem_r, 1'b0, word_r};
  assign out_tuser = {last_r, kind_r};
  assign out_tlast = fend_r;

endmodule

`default_nettype wire

@@ design/daisy_chain_crc15_frame_builder.sv @@
// Order: a command word has its two bytes folded into the PEC before it is offered,
// and a group that fills the frame starts the dump of every held group, newest first.
// Throughput: one input at a time; a group that does not fill the frame is only stored,
// and held groups leave one at a time (load, six one-byte PEC steps, output).
// Reset: synchronous active-low rst_n restores register defaults and empties the
// frame; the group store itself is not cleared.
`default_nettype none

module daisy_chain_crc15_frame_builder (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // Configuration write channel.
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [dccf_pkg::CFG_W-1:0] cfg_data,
  // Input stream.
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [63:0]                in_tdata,   // cmd_word[15:0], group_data[63:16]
  input  wire logic [1:0]                 in_tuser,   // action[1:0]
  // Result stream.
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [63:0]                     out_tdata,  // word_data[47:0], word_pec[63:48]
  output logic [1:0]                      out_tuser,  // word_kind[0], last[1]
  output logic                            out_tlast   // frame_end
);

  dccf_pkg::dccf_cmd_t cmd;
  dccf_pkg::dccf_sts_t sts;

  // Registers accept a write in every cycle.
  assign cfg_ready = 1'b1;

  dccf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid)
  );

  dccf_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

`ifndef SYNTHESIS
  // Input is never taken while a result is on offer.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is pending");

  // The doubled PEC always has a clear low bit.
  a_pec_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[48])
    else $error("PEC bit 0 set");

  // A command word carries nothing above its two bytes.
  a_cmd_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata[47:16] == 32'd0))
    else $error("command word has upper data bits");

  // For register groups the frame ends exactly on the last word of the run.
  a_grp_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tlast == out_tuser[1]))
    else $error("group frame end and run end disagree");
`endif

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;

  // The unused action code; the block must drop it without a result.
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int ITEM_GOAL   = 370;
  localparam int SETTLE      = 24;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 200000;

  // One transmitted word as it leaves the block.
  typedef struct packed {
    logic        kind;
    logic [47:0] data;
    logic [15:0] pec;
    logic        fend;
    logic        last;
  } frame_word_t;

  // One line of the directed table: a register write or an input item.
  typedef struct packed {
    logic                 is_reg;
    dccf_pkg::reg_idx_t   idx;
    logic [14:0]          val;
    logic [1:0]           act;
    logic [15:0]          cmd;
    logic [47:0]          grp;
    logic                 typed;
    frame_word_t          word;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [14:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;    // cmd_word[15:0], group_data[63:16]
  logic [1:0]  in_tuser = '0;    // action[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;        // word_data[47:0], word_pec[63:48]
  logic [1:0]  out_tuser;        // word_kind[0], last[1]
  logic        out_tlast;        // frame_end

  // Predictor copy of the registers and the frame state.
  logic [3:0]  chip_q = dccf_pkg::CHIPS_RST;
  logic [14:0] seed_q = dccf_pkg::SEED_RST;
  logic [14:0] poly_q = dccf_pkg::POLY_RST;
  logic [47:0] store_q [dccf_pkg::MAX_CHIPS];
  int          held_q = 0;

  frame_word_t words_due[$];
  stim_row_t   plan[$];
  int          fed = 0;
  int          errors = 0;
  bit          calm = 1'b0;
  int          stall_ask = 0;
  int          stall_seen = 0;
  int          stall_left = 0;

  daisy_chain_crc15_frame_builder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Groups per frame after clamping a zero count up and a large count down.
  function automatic int frame_size();
    if (chip_q == 4'd0) return 1;
    if (chip_q > dccf_pkg::MAX_CHIPS) return dccf_pkg::MAX_CHIPS;
    return int'(chip_q);
  endfunction

  // Bit-serial CRC15 over the low nbytes bytes, most significant byte first.
  // Shifting one bit at a time gives the same remainder as the byte table.
  function automatic logic [15:0] pec_over(input logic [47:0] bytes_in, input int nbytes);
    logic [14:0] rem;
    logic        fb;
    rem = seed_q;
    for (int i = nbytes * 8 - 1; i >= 0; i--) begin
      fb  = rem[14] ^ bytes_in[i];
      rem = {rem[13:0], 1'b0} ^ (fb ? poly_q : 15'd0);
    end
    return {rem, 1'b0};
  endfunction

  // Work out the words that one accepted item sends and queue them.
  task automatic predict_item(input logic [1:0] act, input logic [15:0] cmd,
                              input logic [47:0] grp);
    frame_word_t w;
    int          n;
    if (act == dccf_pkg::ACT_CMD || act == dccf_pkg::ACT_HDR) begin
      // Any command opens a new frame, so held groups are dropped.
      held_q = 0;
      w.kind = 1'b0;
      w.data = {32'd0, cmd};
      w.pec  = pec_over({32'd0, cmd}, 2);
      w.fend = (act == dccf_pkg::ACT_CMD);
      w.last = 1'b1;
      words_due.push_back(w);
    end else if (act == dccf_pkg::ACT_GRP) begin
      if (held_q < dccf_pkg::MAX_CHIPS) begin
        store_q[held_q] = grp;
        held_q++;
      end
      // A full frame, or one that a lowered count has overrun, goes out newest first.
      if (held_q >= frame_size()) begin
        n = held_q;
        for (int i = n - 1; i >= 0; i--) begin
          w.kind = 1'b1;
          w.data = store_q[i];
          w.pec  = pec_over(store_q[i], 6);
          w.fend = (i == 0);
          w.last = (i == 0);
          words_due.push_back(w);
        end
        held_q = 0;
      end
    end
  endtask

  // Offer one item, with random gaps first, and predict it once accepted.
  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic offer_item(input logic [1:0] act, input logic [15:0] cmd,
                            input logic [47:0] grp);
    while (!calm && $urandom_range(99) < 12) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = act;
    in_tdata  = {grp, cmd};
    do @(posedge clk); while (!in_tready);
    predict_item(act, cmd, grp);
    if (act != ACT_UNUSED) fed++;
    @(negedge clk);
  endtask

  // Write one register once every expected word is out and the block has settled.
  task automatic write_reg(input dccf_pkg::reg_idx_t idx, input logic [14:0] val);
    in_tvalid = 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      dccf_pkg::REG_CHIP_COUNT: chip_q = val[3:0];
      dccf_pkg::REG_PEC_SEED:   seed_q = val;
      dccf_pkg::REG_PEC_POLY:   poly_q = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic void add_item(input logic [1:0] act, input logic [15:0] cmd,
                                   input logic [47:0] grp, input logic typed = 1'b0,
                                   input frame_word_t word = '0);
    stim_row_t r;
    r        = '0;
    r.act    = act;
    r.cmd    = cmd;
    r.grp    = grp;
    r.typed  = typed;
    r.word   = word;
    plan.push_back(r);
  endfunction

  function automatic void add_reg(input dccf_pkg::reg_idx_t idx, input logic [14:0] val);
    stim_row_t r;
    r        = '0;
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    plan.push_back(r);
  endfunction

  function automatic logic [47:0] rand_grp();
    return {$urandom(), 16'($urandom_range(65535))};
  endfunction

  function automatic logic [15:0] rand_cmd();
    return 16'($urandom_range(65535));
  endfunction

  // Receiver: random back-pressure, a long hold when asked, none while calm.
  always @(negedge clk) begin : recv
    if (stall_seen != stall_ask) begin
      stall_seen = stall_ask;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready = 1'b0;
    end else if (calm) begin
      out_tready = 1'b1;
    end else begin
      out_tready = ($urandom_range(99) >= 12);
    end
  end

  // Compare every accepted word with the oldest expectation.
  always @(posedge clk) begin : check
    frame_word_t got;
    frame_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser[0], out_tdata[47:0], out_tdata[63:48], out_tlast, out_tuser[1]};
      if (words_due.size() == 0) begin
        if (errors < 10)
          $display("unexpected word: kind %0d data %h pec %h end %0d last %0d",
                   got.kind, got.data, got.pec, got.fend, got.last);
        errors++;
      end else begin
        want = words_due.pop_front();
        if (got.kind !== want.kind || got.data !== want.data || got.pec !== want.pec ||
            got.fend !== want.fend || got.last !== want.last) begin
          if (errors < 10) begin
            $write("word mismatch: kind %0d/%0d data %h/%h pec %h/%h ",
                   want.kind, got.kind, want.data, got.data, want.pec, got.pec);
            $display("end %0d/%0d last %0d/%0d (expected/actual)",
                     want.fend, got.fend, want.last, got.last);
          end
          errors++;
        end
      end
    end
  end

  // Watchdog on the total cycle count.
  initial begin : watchdog
    int cyc;
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stim
    int cnt_set  [8];
    int seed_set [8];
    int poly_set [8];
    int goal;
    int first_rand;
    int pick;
    int k;

    // With a zero seed, all-zero bytes leave the remainder at zero.
    add_item(dccf_pkg::ACT_CMD, 16'h0000, 48'h0);
    add_item(dccf_pkg::ACT_CMD, 16'hffff, 48'hffff_ffff_ffff);
    add_item(dccf_pkg::ACT_HDR, 16'h1234, 48'h0);
    add_item(dccf_pkg::ACT_GRP, 16'hffff, 48'hffff_ffff_ffff);
    add_item(dccf_pkg::ACT_GRP, 16'h0000, 48'h0);
    add_item(ACT_UNUSED, 16'hffff, 48'hffff_ffff_ffff);
    add_reg(dccf_pkg::REG_PEC_SEED, 15'd0);
    add_item(dccf_pkg::ACT_CMD, 16'h0000, 48'h0, 1'b1, {1'b0, 48'd0, 16'd0, 1'b1, 1'b1});
    add_item(dccf_pkg::ACT_HDR, 16'h0000, 48'h0, 1'b1, {1'b0, 48'd0, 16'd0, 1'b0, 1'b1});
    add_item(dccf_pkg::ACT_GRP, 16'h0000, 48'h0, 1'b1, {1'b1, 48'd0, 16'd0, 1'b1, 1'b1});
    add_reg(dccf_pkg::REG_PEC_POLY, 15'h7fff);
    add_reg(dccf_pkg::REG_PEC_SEED, 15'h7fff);
    // A zero count behaves as one.
    add_reg(dccf_pkg::REG_CHIP_COUNT, 15'd0);
    add_item(dccf_pkg::ACT_GRP, 16'h0000, 48'hffff_ffff_ffff);
    // A count above the chain size saturates at the largest frame.
    add_reg(dccf_pkg::REG_CHIP_COUNT, 15'd15);
    add_item(dccf_pkg::ACT_HDR, 16'ha5a5, 48'h0);
    for (int g = 0; g < dccf_pkg::MAX_CHIPS; g++)
      add_item(dccf_pkg::ACT_GRP, 16'h5a5a, {8{6'(g + 1)}});
    // Lowering the count mid-frame flushes everything held on the next group.
    add_reg(dccf_pkg::REG_CHIP_COUNT, 15'd5);
    for (int g = 0; g < 3; g++)
      add_item(dccf_pkg::ACT_GRP, 16'h0f0f, 48'h0123_4567_89ab + 48'(g));
    add_reg(dccf_pkg::REG_CHIP_COUNT, 15'd2);
    add_item(dccf_pkg::ACT_GRP, 16'hf0f0, 48'hfedc_ba98_7654);
    // A bare command in the middle of a frame discards the held group.
    add_reg(dccf_pkg::REG_CHIP_COUNT, 15'd3);
    add_item(dccf_pkg::ACT_GRP, 16'h0000, 48'h8000_0000_0001);
    add_item(dccf_pkg::ACT_CMD, 16'h8001, 48'h0);

    // Reset and release it at a falling edge.
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table.
    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        offer_item(plan[i].act, plan[i].cmd, plan[i].grp);
        // Rows with a hand-written result use it in place of the computed one.
        if (plan[i].typed) begin
          void'(words_due.pop_back());
          words_due.push_back(plan[i].word);
        end
      end
    end

    // Register settings per random phase; -1 picks a random value.
    cnt_set  = '{8, 1, 0, 15, 3, -1, 2, -1};
    seed_set = '{16, 0, 32767, -1, -1, -1, 16, -1};
    poly_set = '{17817, 32767, 0, -1, 17817, -1, -1, -1};
    first_rand = fed;

    for (int p = 0; p < 8; p++) begin
      write_reg(dccf_pkg::REG_CHIP_COUNT,
                (cnt_set[p] < 0) ? 15'($urandom_range(15)) : 15'(cnt_set[p]));
      write_reg(dccf_pkg::REG_PEC_SEED,
                (seed_set[p] < 0) ? 15'($urandom_range(32767)) : 15'(seed_set[p]));
      write_reg(dccf_pkg::REG_PEC_POLY,
                (poly_set[p] < 0) ? 15'($urandom_range(32767)) : 15'(poly_set[p]));
      // Long receiver hold during full frames so the block backs up into its input.
      if (p == 0) stall_ask++;
      calm = (p == 3);
      goal = first_rand + (p + 1) * (ITEM_GOAL - first_rand) / 8;
      while (fed < goal) begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          // Well-formed write frame.
          offer_item(dccf_pkg::ACT_HDR, rand_cmd(), rand_grp());
          k = frame_size();
          for (int g = 0; g < k; g++)
            offer_item(dccf_pkg::ACT_GRP, rand_cmd(), rand_grp());
        end else if (pick < 70) begin
          offer_item(dccf_pkg::ACT_CMD, rand_cmd(), rand_grp());
        end else if (pick < 78) begin
          offer_item(ACT_UNUSED, rand_cmd(), rand_grp());
        end else if (pick < 90) begin
          offer_item(dccf_pkg::ACT_GRP, rand_cmd(), rand_grp());
        end else begin
          // Frame cut short by a new command.
          offer_item(dccf_pkg::ACT_HDR, rand_cmd(), rand_grp());
          k = $urandom_range(frame_size() - 1);
          for (int g = 0; g < k; g++)
            offer_item(dccf_pkg::ACT_GRP, rand_cmd(), rand_grp());
          offer_item(($urandom_range(1) == 0) ? dccf_pkg::ACT_CMD : dccf_pkg::ACT_HDR,
                     rand_cmd(), rand_grp());
        end
      end
      calm = 1'b0;
    end

    // Drain and let the block settle.
    in_tvalid = 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (errors == 0 && words_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
